FILE: rtl/rau_pkg.sv
// Package: shared types and constants for the rational arithmetic unit.
package rau_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int WIDE_W = 64;
	localparam int DEN_OUT_W = 63;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	// Datapath phase select driven by the controller.
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_LOAD = 3'd1,
		OP_MUL1 = 3'd2,
		OP_MUL2 = 3'd3,
		OP_MUL3 = 3'd4,
		OP_MAG = 3'd5,
		OP_GCD = 3'd6,
		OP_DIV = 3'd7
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic div_init;
	} dp_cmd_t;

	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} dp_sts_t;

endpackage

FILE: rtl/rational_arith_unit.sv
// Rational arithmetic unit: one item in flight, s_tready is high only while idle.
// Error items go from load straight to the output state; all others pass through the three
// products, the binary gcd steps and the two exact divisions before the output state.
// A result not yet taken holds the controller in its output state and so stalls the next one.
// arst_n clears the controller and the output valid; datapath registers are reloaded per item.
module rational_arith_unit #(
	parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// action[1:0], a_num[33:2], a_den[64:34], b_num[96:65], b_den[127:97]
	input  logic [127:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// res_num[63:0], res_den[126:64], status[128:127], zero pad to 136
	output logic [135:0]  m_tdata
);
	import rau_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic idle, done, in_fire;
	logic signed [63:0] res_num;
	logic [62:0] res_den;
	logic [1:0] status;
	logic vld_q;
	logic [135:0] dat_q;

	assign s_tready = idle;
	assign in_fire = s_tvalid && s_tready;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(vld_q && !m_tready),
		.sts(sts), .cmd(cmd), .idle(idle), .done(done)
	);

	rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .action(s_tdata[1:0]), .a_num(s_tdata[33:2]), .a_den(s_tdata[64:34]),
		.b_num(s_tdata[96:65]), .b_den(s_tdata[127:97]), .cmd(cmd), .sts(sts),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (done) vld_q <= 1'b1;
		else if (m_tready) vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) dat_q <= {7'd0, status, res_den, res_num};
	end

	assign m_tvalid = vld_q;
	assign m_tdata = dat_q;

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !m_tready |=> vld_q) else $error("result dropped");
	a_no_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(vld_q && !m_tready)) else $error("result overwritten");
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> dat_q[126:64] != '0) else $error("zero denominator out");
`endif
endmodule

FILE: rtl/rau_ctrl.sv
// Controller: sequences load, three products, gcd and the two exact divisions; error items skip to output.
module rau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_busy,
	input  rau_pkg::dp_sts_t   sts,
	output rau_pkg::dp_cmd_t   cmd,
	output logic               idle,
	output logic               done
);
	import rau_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b0_0000_0001,
		S_MUL1 = 9'b0_0000_0010,
		S_MUL2 = 9'b0_0000_0100,
		S_MUL3 = 9'b0_0000_1000,
		S_MAG  = 9'b0_0001_0000,
		S_GCD  = 9'b0_0010_0000,
		S_DIVN = 9'b0_0100_0000,
		S_DIVD = 9'b0_1000_0000,
		S_OUT  = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign idle = (state_q == S_IDLE);

	// Decode state into datapath command and next state
	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.div_init = 1'b0;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.op = OP_LOAD;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				if (sts.early) state_d = S_OUT;
				else begin
					cmd.op = OP_MUL1;
					state_d = S_MUL2;
				end
			end
			S_MUL2: begin
				cmd.op = OP_MUL2;
				state_d = S_MUL3;
			end
			S_MUL3: begin
				cmd.op = OP_MUL3;
				state_d = S_MAG;
			end
			S_MAG: begin
				cmd.op = OP_MAG;
				state_d = S_GCD;
			end
			S_GCD: begin
				cmd.op = OP_GCD;
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = S_DIVN;
				end
			end
			S_DIVN: begin
				cmd.op = OP_DIV;
				if (sts.div_done) begin
					cmd.div_init = 1'b1;
					state_d = S_DIVD;
				end
			end
			S_DIVD: begin
				cmd.op = OP_DIV;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_fire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("item taken while busy");
	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_MUL1) else $error("load did not advance");
`endif
endmodule

FILE: rtl/rau_dp.sv
// Datapath: operand registers, shared multiplier, binary gcd, restoring divider.
module rau_dp #(
	parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic [1:0]           action,
	input  logic signed [31:0]   a_num,
	input  logic [30:0]          a_den,
	input  logic signed [31:0]   b_num,
	input  logic [30:0]          b_den,
	input  rau_pkg::dp_cmd_t     cmd,
	output rau_pkg::dp_sts_t     sts,
	output logic signed [63:0]   res_num,
	output logic [62:0]          res_den,
	output logic [1:0]           status
);
	import rau_pkg::*;

	localparam int DW = VALUE_WIDTH - 1;
	localparam int CW = $clog2(WIDE_W + 1);

	logic [1:0] act_q;
	logic signed [VALUE_WIDTH-1:0] an_q, bn_q;
	logic [DW-1:0] ad_q, bd_q;
	status_t st_q;
	logic signed [WIDE_W-1:0] p1_q, p2_q, d_q;
	logic [WIDE_W-1:0] nm_q, dm_q, gx_q, gy_q, g_q;
	logic neg_q;
	logic [CW-1:0] sh_q;
	logic [WIDE_W-1:0] rem_q, dvd_q;
	logic [CW-1:0] bit_q;
	logic [WIDE_W-1:0] qn_q;

	// Shared multiplier: an*bd (an*bn for multiply), then bn*ad, then the denominator
	logic signed [VALUE_WIDTH:0] an_x, bn_x, ad_x, bd_x, ma, mb;
	logic signed [2*VALUE_WIDTH+1:0] mp;
	assign an_x = $signed({an_q[VALUE_WIDTH-1], an_q});
	assign bn_x = $signed({bn_q[VALUE_WIDTH-1], bn_q});
	assign ad_x = $signed({2'b00, ad_q});
	assign bd_x = $signed({2'b00, bd_q});
	always_comb begin
		ma = an_x;
		mb = (act_q == ACT_MUL) ? bn_x : bd_x;
		case (cmd.op)
			OP_MUL2: begin
				ma = bn_x;
				mb = ad_x;
			end
			OP_MUL3: begin
				ma = ad_x;
				mb = (act_q == ACT_DIV) ? bn_x : bd_x;
			end
			default: ;
		endcase
		mp = ma * mb;
	end

	// Numerator from the products, magnitudes of numerator and denominator
	logic signed [WIDE_W-1:0] nsum;
	always_comb begin
		case (act_q)
			ACT_ADD: nsum = p1_q + p2_q;
			ACT_SUB: nsum = p1_q - p2_q;
			default: nsum = p1_q;
		endcase
	end
	logic [WIDE_W-1:0] nmag, dmag;
	assign nmag = nsum[WIDE_W-1] ? -nsum : nsum;
	assign dmag = d_q[WIDE_W-1] ? -d_q : d_q;

	// Binary gcd step
	logic gcd_fin;
	assign gcd_fin = (gy_q == '0) || (gx_q == '0);
	assign sts.gcd_done = gcd_fin;
	assign sts.early = (st_q != ST_OK);
	assign sts.div_done = (bit_q == '0);

	logic [WIDE_W-1:0] rsh, gsel;
	assign gsel = (gx_q == '0) ? gy_q : gx_q;
	assign rsh = {rem_q[WIDE_W-2:0], dvd_q[WIDE_W-1]};

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				act_q <= action;
				an_q <= a_num[VALUE_WIDTH-1:0];
				bn_q <= b_num[VALUE_WIDTH-1:0];
				ad_q <= a_den[DW-1:0];
				bd_q <= b_den[DW-1:0];
				if (a_den[DW-1:0] == '0 || b_den[DW-1:0] == '0) st_q <= ST_ZERO_DEN;
				else if (action == ACT_DIV && b_num[VALUE_WIDTH-1:0] == '0) st_q <= ST_DIV_ZERO;
				else st_q <= ST_OK;
			end
			OP_MUL1: p1_q <= WIDE_W'(mp);
			OP_MUL2: p2_q <= WIDE_W'(mp);
			OP_MUL3: d_q <= WIDE_W'(mp);
			OP_MAG: begin
				neg_q <= nsum[WIDE_W-1] ^ d_q[WIDE_W-1];
				nm_q <= nmag;
				dm_q <= dmag;
				gx_q <= nmag;
				gy_q <= dmag;
				sh_q <= '0;
			end
			OP_GCD: begin
				if (!gcd_fin) begin
					if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else if (!gx_q[0]) gx_q <= gx_q >> 1;
					else if (!gy_q[0]) gy_q <= gy_q >> 1;
					else if (gx_q >= gy_q) gx_q <= (gx_q - gy_q) >> 1;
					else gy_q <= (gy_q - gx_q) >> 1;
				end
				// Start dividing the numerator magnitude by the gcd
				if (cmd.div_init) begin
					g_q <= (gsel << sh_q);
					dvd_q <= nm_q;
					rem_q <= '0;
					bit_q <= CW'(WIDE_W);
				end
			end
			OP_DIV: begin
				if (bit_q != '0) begin
					if (rsh >= g_q) begin
						rem_q <= rsh - g_q;
						dvd_q <= {dvd_q[WIDE_W-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						dvd_q <= {dvd_q[WIDE_W-2:0], 1'b0};
					end
					bit_q <= bit_q - 1'b1;
				end
				// Keep the numerator quotient, then divide the denominator
				if (cmd.div_init) begin
					qn_q <= dvd_q;
					dvd_q <= dm_q;
					rem_q <= '0;
					bit_q <= CW'(WIDE_W);
				end
			end
			default: ;
		endcase
	end

	// Result formatting
	always_comb begin
		status = st_q;
		if (st_q != ST_OK || qn_q == '0) begin
			res_num = '0;
			res_den = 63'd1;
		end else begin
			res_num = neg_q ? -$signed(qn_q) : $signed(qn_q);
			res_den = dvd_q[DEN_OUT_W-1:0];
		end
	end
endmodule

FILE: tb/tb.sv
// Testbench for the rational arithmetic unit: stream driver, monitor and fraction predictor.
`timescale 1ns / 1ps
module tb;
	import rau_pkg::*;

	localparam int NUM_RANDOM = 1800;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct packed {
		logic [62:0] den;
		logic [63:0] num;
		status_t     st;
	} fraction_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [127:0]  s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [135:0]  m_tdata;

	logic [127:0]  pending_items[$];
	fraction_t     expected_fracs[$];
	int            mismatches = 0;
	int            results_seen = 0;
	int            cycles = 0;
	bit            stim_done = 1'b0;
	bit            hold_sender;
	bit            item_taken;
	int            send_gap;
	int            take_gap;

	rational_arith_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Generate clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [127:0] pack_item(action_t act, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		return {bd, bn, ad, an, act};
	endfunction

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Compute the reduced fraction for one item
	function automatic fraction_t reduce_fraction(logic [127:0] item);
		fraction_t r;
		action_t act;
		logic signed [63:0] an, ad, bn, bd, n, d;
		logic [63:0] nm, dm, g;
		act = action_t'(item[1:0]);
		an = {{32{item[33]}}, item[33:2]};
		ad = {33'd0, item[64:34]};
		bn = {{32{item[96]}}, item[96:65]};
		bd = {33'd0, item[127:97]};
		r.num = 64'd0;
		r.den = 63'd1;
		if (ad == 0 || bd == 0) begin
			r.st = ST_ZERO_DEN;
			return r;
		end
		if (act == ACT_DIV && bn == 0) begin
			r.st = ST_DIV_ZERO;
			return r;
		end
		case (act)
			ACT_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
			ACT_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
			ACT_MUL: begin n = an * bn; d = ad * bd; end
			default: begin n = an * bd; d = ad * bn; end
		endcase
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		g = euclid_gcd(nm, dm);
		if (g == 0) g = 1;
		nm = nm / g;
		dm = dm / g;
		if (nm == 0) dm = 1;
		r.num = ((n < 0) != (d < 0)) ? -nm : nm;
		r.den = dm[62:0];
		r.st = ST_OK;
		return r;
	endfunction

	function automatic logic [31:0] rand_num();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 20) - 10;
			3: return $urandom_range(0, 1000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] rand_den();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return 31'h7fff_ffff;
			2: return 31'd1;
			3: return 31'($urandom_range(1, 100));
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(20, 400);
		return $urandom_range(1, 4);
	endfunction

	// Fill the item queue: directed corners first, then random
	initial begin
		pending_items.push_back(pack_item(ACT_ADD, 32'd1, 31'd2, 32'd1, 31'd3));
		pending_items.push_back(pack_item(ACT_SUB, 32'd1, 31'd2, 32'd1, 31'd2));
		pending_items.push_back(pack_item(ACT_MUL, -32'sd3, 31'd4, 32'd2, 31'd9));
		pending_items.push_back(pack_item(ACT_DIV, 32'd3, 31'd4, -32'sd6, 31'd8));
		pending_items.push_back(pack_item(ACT_ADD, 32'd1, 31'd0, 32'd1, 31'd1));
		pending_items.push_back(pack_item(ACT_DIV, 32'd1, 31'd1, 32'd5, 31'd0));
		pending_items.push_back(pack_item(ACT_DIV, 32'd7, 31'd3, 32'd0, 31'd5));
		pending_items.push_back(pack_item(ACT_DIV, 32'd0, 31'd0, 32'd0, 31'd5));
		pending_items.push_back(pack_item(ACT_MUL, 32'd0, 31'd7, 32'd5, 31'd3));
		pending_items.push_back(pack_item(ACT_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1));
		pending_items.push_back(pack_item(ACT_ADD, 32'h8000_0000, 31'h7fff_ffff,
			32'h8000_0000, 31'h7fff_fffe));
		pending_items.push_back(pack_item(ACT_SUB, 32'h7fff_ffff, 31'h7fff_ffff,
			32'h8000_0000, 31'h7fff_ffff));
		pending_items.push_back(pack_item(ACT_DIV, 32'h8000_0000, 31'h7fff_ffff,
			32'h7fff_ffff, 31'd1));
		pending_items.push_back(pack_item(ACT_DIV, -32'sd1, 31'h7fff_ffff, -32'sd1, 31'd1));
		pending_items.push_back(pack_item(ACT_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1));
		pending_items.push_back(pack_item(ACT_MUL, 32'hffff_ffff, 31'h5555_5555,
			32'hffff_ffff, 31'h2aaa_aaaa));
		for (int i = 0; i < NUM_RANDOM; i++)
			pending_items.push_back(pack_item(action_t'($urandom_range(0, 3)), rand_num(),
				rand_den(), rand_num(), rand_den()));
	end

	// Note which rising edge took the offered item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) item_taken <= 1'b0;
		else item_taken <= s_tvalid && s_tready;
	end

	// Drive items at the falling edge, pausing once for a full drain
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
			hold_sender <= 1'b0;
		end else if (!s_tvalid || item_taken) begin
			if (pending_items.size() == 900 && !hold_sender && expected_fracs.size() != 0) begin
				s_tvalid <= 1'b0;
			end else if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
				hold_sender <= 1'b0;
			end else if (pending_items.size() != 0) begin
				if (pending_items.size() == 900) hold_sender <= 1'b1;
				s_tvalid <= 1'b1;
				s_tdata <= pending_items.pop_front();
				send_gap <= rand_gap();
			end else begin
				s_tvalid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap <= 0;
		end else if (take_gap > 0) begin
			m_tready <= 1'b0;
			take_gap <= take_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if (m_tready) take_gap <= rand_gap();
		end
	end

	// Record expectations and check results at the rising edge
	always @(posedge clk) begin
		fraction_t want, got;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (s_tvalid && s_tready) expected_fracs.push_back(reduce_fraction(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[126:64], m_tdata[63:0], status_t'(m_tdata[128:127])};
				results_seen <= results_seen + 1;
				if (expected_fracs.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected result %h", m_tdata);
				end else begin
					want = expected_fracs.pop_front();
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
								$signed(want.num), want.den, want.st,
								$signed(got.num), got.den, got.st);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done && expected_fracs.size() == 0);
		repeat (300) @(posedge clk);
		$display("covered %0d items over all four operations, zero denominators,", results_seen);
		$display("divide by zero fractions and extreme operands with random stalls");
		if (mismatches == 0 && expected_fracs.size() == 0)
			$display("[rational_arith_unit] OK");
		else
			$display("[rational_arith_unit] ERROR");
		$finish;
	end

	// Abort on timeout
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("[rational_arith_unit] ERROR");
			$finish;
		end
	end

endmodule
